// File: src/bgls_pkg.sv
// ----------------------------------------------------------------------------
// bgls_pkg: shared types and constants for the button gesture LED sequencer
// Payload structs, the configuration register set and its reset values.
// ----------------------------------------------------------------------------
package bgls_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE     = 3'd0,
    REG_SHORT_MIN    = 3'd1,
    REG_PORTAL_MIN   = 3'd2,
    REG_FACTORY_HOLD = 3'd3,
    REG_MAX_ATTEMPTS = 3'd4,
    REG_RETRY_DELAY  = 3'd5,
    REG_FAIL_FLASH   = 3'd6,
    REG_POST_WAIT    = 3'd7
  } reg_idx_t;

  // reset values of the configuration registers
  localparam logic [7:0]  DEBOUNCE_RST     = 8'd20;
  localparam logic [15:0] SHORT_MIN_RST    = 16'd50;
  localparam logic [15:0] PORTAL_MIN_RST   = 16'd5000;
  localparam logic [15:0] FACTORY_HOLD_RST = 16'd12000;
  localparam logic [2:0]  MAX_ATTEMPTS_RST = 3'd2;
  localparam logic [9:0]  RETRY_DELAY_RST  = 10'd25;
  localparam logic [9:0]  FAIL_FLASH_RST   = 10'd50;
  localparam logic [9:0]  POST_WAIT_RST    = 10'd500;

  // timing limits
  localparam logic [9:0]  BLINK_MS   = 10'd100;
  localparam logic [9:0]  PHASE_MAX  = 10'd1023;
  localparam logic [7:0]  STABLE_MAX = 8'd255;
  localparam logic [15:0] HOLD_MAX   = 16'hFFFF;
  localparam logic [2:0]  FAIL_MAX   = 3'd7;

  typedef struct packed {
    logic [7:0]  debounce_ms;
    logic [15:0] short_min_ms;
    logic [15:0] portal_min_ms;
    logic [15:0] factory_hold_ms;
    logic [2:0]  max_attempts;
    logic [9:0]  retry_delay_ms;
    logic [9:0]  fail_flash_ms;
    logic [9:0]  post_wait_ms;
  } cfg_t;

  typedef struct packed {
    logic button_raw;
    logic publish_ok;
  } in_item_t;

  typedef struct packed {
    logic led_on;
    logic led_hold;
    logic publish_attempt;
    logic portal_request;
    logic factory_reset;
    logic sequence_active;
    logic button_level;
  } out_item_t;

  // classified tick passed from the button front end to the LED sequencer
  typedef struct packed {
    logic short_press;
    logic portal;
    logic factory;
    logic level;
    logic ok;
  } event_t;

endpackage

// File: src/bgls_front.sv
// ----------------------------------------------------------------------------
// bgls_front: button debounce and press classification
// Debounces the raw level, times the hold and flags short, portal and
// factory-reset gestures for each accepted tick.
// ----------------------------------------------------------------------------
module bgls_front (
  input  logic             clk,
  input  logic             rst,
  input  bgls_pkg::cfg_t   cfg,
  input  logic             accept,
  input  bgls_pkg::in_item_t item,
  output bgls_pkg::event_t evt
);
  import bgls_pkg::*;

  logic        last_raw, last_raw_next;
  logic [7:0]  stable_ticks, stable_ticks_next;
  logic        debounced, debounced_next;
  logic        held_down, held_down_next;
  logic [15:0] hold_ticks, hold_ticks_next;
  logic        reset_fired, reset_fired_next;
  logic [15:0] hold_inc;
  logic        in_short, in_portal;

  // debounce and press timing for one tick
  always_comb begin
    last_raw_next     = last_raw;
    stable_ticks_next = stable_ticks;
    held_down_next    = held_down;
    reset_fired_next  = reset_fired;
    evt               = '0;

    if (item.button_raw != last_raw) begin
      last_raw_next     = item.button_raw;
      stable_ticks_next = '0;
    end else if (stable_ticks < STABLE_MAX) begin
      stable_ticks_next = stable_ticks + 8'd1;
    end
    debounced_next = (stable_ticks_next >= cfg.debounce_ms) ? last_raw_next : debounced;

    hold_inc = (held_down && hold_ticks < HOLD_MAX) ? hold_ticks + 16'd1 : hold_ticks;
    hold_ticks_next = hold_inc;

    in_short  = !reset_fired && hold_inc >= cfg.short_min_ms && hold_inc < cfg.portal_min_ms;
    in_portal = !reset_fired && hold_inc >= cfg.portal_min_ms &&
                hold_inc < cfg.factory_hold_ms;

    if (debounced_next) begin
      if (!held_down) begin
        held_down_next   = 1'b1;
        hold_ticks_next  = '0;
        reset_fired_next = 1'b0;
      end else if (!reset_fired && hold_inc >= cfg.factory_hold_ms) begin
        reset_fired_next = 1'b1;
        evt.factory      = 1'b1;
      end
    end else if (held_down) begin
      // release: short window wins over portal window
      evt.short_press  = in_short;
      evt.portal       = !in_short && in_portal;
      held_down_next   = 1'b0;
      reset_fired_next = 1'b0;
    end

    evt.level = debounced_next;
    evt.ok    = item.publish_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_raw     <= 1'b0;
      stable_ticks <= '0;
      debounced    <= 1'b0;
      held_down    <= 1'b0;
      hold_ticks   <= '0;
      reset_fired  <= 1'b0;
    end else if (accept) begin
      last_raw     <= last_raw_next;
      stable_ticks <= stable_ticks_next;
      debounced    <= debounced_next;
      held_down    <= held_down_next;
      hold_ticks   <= hold_ticks_next;
      reset_fired  <= reset_fired_next;
    end
  end

  // a fired factory reset only exists within a press
  a_fired_in_press: assert property (@(posedge clk) disable iff (rst)
    reset_fired |-> held_down)
    else $error("factory reset flag set outside a press");

endmodule

// File: src/bgls_evq.sv
// ----------------------------------------------------------------------------
// bgls_evq: two-entry event queue
// Decouples the button front end from the LED sequencer.
// ----------------------------------------------------------------------------
module bgls_evq (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  bgls_pkg::event_t evt_in,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output bgls_pkg::event_t evt_out
);
  import bgls_pkg::*;

  event_t     q [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       do_push, do_pop;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign evt_out = q[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= evt_in;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("event queue overfilled");

endmodule

// File: src/bgls_back.sv
// ----------------------------------------------------------------------------
// bgls_back: LED send sequencer with result queue
// Runs the blink, publish, retry and fail-flash phases on each classified
// tick and queues one result per tick.
// ----------------------------------------------------------------------------
module bgls_back (
  input  logic                clk,
  input  logic                rst,
  input  bgls_pkg::cfg_t      cfg,
  input  logic                evt_valid,
  input  bgls_pkg::event_t    evt,
  output logic                evt_take,
  input  logic                pop,
  output logic                empty,
  output bgls_pkg::out_item_t out_item
);
  import bgls_pkg::*;

  typedef enum logic [4:0] {
    PH_IDLE      = 5'd0,
    PH_PRE_ON1   = 5'd1,
    PH_PRE_OFF1  = 5'd2,
    PH_PRE_ON2   = 5'd3,
    PH_PRE_OFF2  = 5'd4,
    PH_TRY       = 5'd5,
    PH_RETRY     = 5'd6,
    PH_POST_WAIT = 5'd7,
    PH_POST_ON1  = 5'd8,
    PH_POST_OFF1 = 5'd9,
    PH_POST_ON2  = 5'd10,
    PH_POST_OFF2 = 5'd11,
    PH_FAIL_ON1  = 5'd12,
    PH_FAIL_OFF1 = 5'd13,
    PH_FAIL_ON2  = 5'd14,
    PH_FAIL_OFF2 = 5'd15,
    PH_FAIL_ON3  = 5'd16,
    PH_FAIL_OFF3 = 5'd17
  } phase_t;

  phase_t     phase, phase_next;
  logic [9:0] elapsed, elapsed_next, elapsed_inc;
  logic [9:0] length, length_next;
  logic [2:0] fail_count, fail_next, fail_inc;
  logic       led_level, led_next;
  logic       attempt, seq_done;
  out_item_t  res;

  out_item_t  oq [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] out_count;
  logic       do_pop;

  assign evt_take = evt_valid && (out_count != 2'd2);
  assign empty    = (out_count == 2'd0);
  assign do_pop   = pop && !empty;
  assign out_item = oq[rd_ptr];

  // phase advance for one tick
  always_comb begin
    phase_next  = phase;
    elapsed_next = elapsed;
    length_next = length;
    fail_next   = fail_count;
    led_next    = led_level;
    attempt     = 1'b0;
    seq_done    = 1'b0;
    elapsed_inc = (elapsed < PHASE_MAX) ? elapsed + 10'd1 : elapsed;
    fail_inc    = (fail_count < FAIL_MAX) ? fail_count + 3'd1 : fail_count;

    if (evt.short_press && phase == PH_IDLE) begin
      // start tick: armed, no advance
      led_next     = 1'b1;
      phase_next   = PH_PRE_ON1;
      elapsed_next = '0;
      length_next  = BLINK_MS;
    end else if (phase != PH_IDLE) begin
      elapsed_next = elapsed_inc;
      if (elapsed_inc >= length) begin
        elapsed_next = '0;
        length_next  = '0;
        unique case (phase) inside
          PH_PRE_ON1: begin
            led_next = 1'b0; phase_next = PH_PRE_OFF1; length_next = BLINK_MS;
          end
          PH_PRE_OFF1: begin
            led_next = 1'b1; phase_next = PH_PRE_ON2; length_next = BLINK_MS;
          end
          PH_PRE_ON2: begin
            led_next = 1'b0; phase_next = PH_PRE_OFF2; length_next = BLINK_MS;
          end
          PH_PRE_OFF2: begin
            fail_next = '0; phase_next = PH_TRY;
          end
          PH_TRY: begin
            attempt = 1'b1;
            if (evt.ok) begin
              phase_next  = PH_POST_WAIT;
              length_next = cfg.post_wait_ms;
            end else begin
              fail_next = fail_inc;
              if (fail_inc >= cfg.max_attempts) begin
                led_next    = 1'b1;
                phase_next  = PH_FAIL_ON1;
                length_next = cfg.fail_flash_ms;
              end else begin
                phase_next  = PH_RETRY;
                length_next = cfg.retry_delay_ms;
              end
            end
          end
          PH_RETRY: begin
            phase_next = PH_TRY;
          end
          PH_POST_WAIT: begin
            led_next = 1'b1; phase_next = PH_POST_ON1; length_next = BLINK_MS;
          end
          PH_POST_ON1: begin
            led_next = 1'b0; phase_next = PH_POST_OFF1; length_next = BLINK_MS;
          end
          PH_POST_OFF1: begin
            led_next = 1'b1; phase_next = PH_POST_ON2; length_next = BLINK_MS;
          end
          PH_POST_ON2: begin
            led_next = 1'b0; phase_next = PH_POST_OFF2; length_next = BLINK_MS;
          end
          PH_FAIL_ON1: begin
            led_next = 1'b0; phase_next = PH_FAIL_OFF1; length_next = cfg.fail_flash_ms;
          end
          PH_FAIL_OFF1: begin
            led_next = 1'b1; phase_next = PH_FAIL_ON2; length_next = cfg.fail_flash_ms;
          end
          PH_FAIL_ON2: begin
            led_next = 1'b0; phase_next = PH_FAIL_OFF2; length_next = cfg.fail_flash_ms;
          end
          PH_FAIL_OFF2: begin
            led_next = 1'b1; phase_next = PH_FAIL_ON3; length_next = cfg.fail_flash_ms;
          end
          PH_FAIL_ON3: begin
            led_next = 1'b0; phase_next = PH_FAIL_OFF3; length_next = cfg.fail_flash_ms;
          end
          PH_POST_OFF2, PH_FAIL_OFF3: begin
            phase_next = PH_IDLE;
            seq_done   = 1'b1;
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end
    end

    res.led_on          = led_next;
    res.led_hold        = seq_done;
    res.publish_attempt = attempt;
    res.portal_request  = evt.portal;
    res.factory_reset   = evt.factory;
    res.sequence_active = (phase_next != PH_IDLE);
    res.button_level    = evt.level;
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      elapsed    <= '0;
      length     <= '0;
      fail_count <= '0;
      led_level  <= 1'b0;
    end else if (evt_take) begin
      phase      <= phase_next;
      elapsed    <= elapsed_next;
      length     <= length_next;
      fail_count <= fail_next;
      led_level  <= led_next;
    end
  end

  // result queue storage
  always_ff @(posedge clk) begin
    if (evt_take) begin
      oq[wr_ptr] <= res;
    end
  end

  // result queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= 1'b0;
      rd_ptr    <= 1'b0;
      out_count <= '0;
    end else begin
      if (evt_take) wr_ptr <= ~wr_ptr;
      if (do_pop)   rd_ptr <= ~rd_ptr;
      case ({evt_take, do_pop})
        2'b10:   out_count <= out_count + 2'd1;
        2'b01:   out_count <= out_count - 2'd1;
        default: out_count <= out_count;
      endcase
    end
  end

  a_hold_idle: assert property (@(posedge clk) disable iff (rst)
    (evt_take && res.led_hold) |-> !res.sequence_active)
    else $error("hold pulse while sequence still active");

  a_attempt_in_try: assert property (@(posedge clk) disable iff (rst)
    (evt_take && res.publish_attempt) |-> (phase == PH_TRY))
    else $error("publish attempt outside try phase");

  a_out_count: assert property (@(posedge clk) disable iff (rst)
    out_count != 2'd3)
    else $error("result queue overfilled");

endmodule

// File: src/button_gesture_led_sequencer_unit.sv
// ----------------------------------------------------------------------------
// button_gesture_led_sequencer_unit: debounced button gestures and LED sequence
// One item per millisecond tick; debounce and press timing in the front end,
// LED send sequencer in the back end, an event queue between them.
//
//   channel   handshake            payload
//   --------  -------------------  ------------------------------------------
//   input     push / full          in_data  (button_raw, publish_ok)
//   result    empty / pop          out_data (led_on .. button_level)
//   config    cfg_valid/cfg_ready  cfg_index, cfg_data (low bits used)
//
// One item per cycle sustained while results are popped; each item yields one result.
// A pushed item is registered in the event queue; the sequencer then takes it and
// writes its result into the result queue, unless the result queue is full.
// Sync reset restores register defaults and clears all state but queue storage.
// full rises when the event queue holds two items; a stalled pop backs up
// through the result queue into the event queue.
// cfg_ready is always high.
// ----------------------------------------------------------------------------
module button_gesture_led_sequencer_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  bgls_pkg::in_item_t               in_data,
  output logic                             empty,
  input  logic                             pop,
  output bgls_pkg::out_item_t              out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bgls_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bgls_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import bgls_pkg::*;

  cfg_t   cfg;
  event_t front_evt, back_evt;
  logic   accept, evq_empty, evt_take;

  assign cfg_ready = 1'b1;
  assign accept    = push && !full;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms     <= DEBOUNCE_RST;
      cfg.short_min_ms    <= SHORT_MIN_RST;
      cfg.portal_min_ms   <= PORTAL_MIN_RST;
      cfg.factory_hold_ms <= FACTORY_HOLD_RST;
      cfg.max_attempts    <= MAX_ATTEMPTS_RST;
      cfg.retry_delay_ms  <= RETRY_DELAY_RST;
      cfg.fail_flash_ms   <= FAIL_FLASH_RST;
      cfg.post_wait_ms    <= POST_WAIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_DEBOUNCE:     cfg.debounce_ms     <= cfg_data[7:0];
        REG_SHORT_MIN:    cfg.short_min_ms    <= cfg_data;
        REG_PORTAL_MIN:   cfg.portal_min_ms   <= cfg_data;
        REG_FACTORY_HOLD: cfg.factory_hold_ms <= cfg_data;
        REG_MAX_ATTEMPTS: cfg.max_attempts    <= cfg_data[2:0];
        REG_RETRY_DELAY:  cfg.retry_delay_ms  <= cfg_data[9:0];
        REG_FAIL_FLASH:   cfg.fail_flash_ms   <= cfg_data[9:0];
        REG_POST_WAIT:    cfg.post_wait_ms    <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  bgls_front u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .accept (accept),
    .item   (in_data),
    .evt    (front_evt)
  );

  bgls_evq u_evq (
    .clk     (clk),
    .rst     (rst),
    .push    (accept),
    .evt_in  (front_evt),
    .full    (full),
    .pop     (evt_take),
    .empty   (evq_empty),
    .evt_out (back_evt)
  );

  bgls_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .evt_valid (!evq_empty),
    .evt       (back_evt),
    .evt_take  (evt_take),
    .pop       (pop),
    .empty     (empty),
    .out_item  (out_data)
  );

endmodule

// File: test/tb_button_gesture_led_sequencer_unit.sv
// ----------------------------------------------------------------------------
// tb_button_gesture_led_sequencer_unit: self-checking bench for the button unit
// A clocked driver pushes millisecond ticks from a pending queue. A tick-level
// predictor of the debounce, press timing and LED sequencer computes the
// result of every accepted tick. A clocked monitor pops results and compares
// each one with the oldest prediction. Register sets change between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_button_gesture_led_sequencer_unit;
  import bgls_pkg::*;

  typedef enum logic [4:0] {
    PH_IDLE, PH_PRE_ON1, PH_PRE_OFF1, PH_PRE_ON2, PH_PRE_OFF2, PH_TRY, PH_RETRY,
    PH_POST_WAIT, PH_POST_ON1, PH_POST_OFF1, PH_POST_ON2, PH_POST_OFF2,
    PH_FAIL_ON1, PH_FAIL_OFF1, PH_FAIL_ON2, PH_FAIL_OFF2, PH_FAIL_ON3, PH_FAIL_OFF3
  } led_phase_t;

  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  push      = 1'b0;
  logic                  full;
  in_item_t              in_data   = '0;
  logic                  empty;
  logic                  pop       = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // ticks waiting to be pushed, predicted results waiting to be popped
  in_item_t  pending_ticks[$];
  out_item_t tick_results[$];
  int        ticks_issued  = 0;
  int        ticks_checked = 0;
  int        queued        = 0;
  int        mismatches    = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  int        idle_cycles   = 0;

  // predictor copy of the registers and the block state
  cfg_t live_cfg = '{debounce_ms: DEBOUNCE_RST, short_min_ms: SHORT_MIN_RST,
                     portal_min_ms: PORTAL_MIN_RST, factory_hold_ms: FACTORY_HOLD_RST,
                     max_attempts: MAX_ATTEMPTS_RST, retry_delay_ms: RETRY_DELAY_RST,
                     fail_flash_ms: FAIL_FLASH_RST, post_wait_ms: POST_WAIT_RST};
  logic        last_raw      = 1'b0;
  logic [7:0]  stable_ticks  = '0;
  logic        debounced     = 1'b0;
  logic        held_down     = 1'b0;
  logic [15:0] hold_ticks    = '0;
  logic        reset_fired   = 1'b0;
  led_phase_t  led_phase     = PH_IDLE;
  logic [9:0]  phase_elapsed = '0;
  logic [9:0]  phase_length  = '0;
  logic [2:0]  fail_count    = '0;
  logic        led_level     = 1'b0;

  button_gesture_led_sequencer_unit dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function void arm_phase(led_phase_t ph, logic [9:0] len);
    led_phase     = ph;
    phase_elapsed = '0;
    phase_length  = len;
  endfunction

  // one tick of the LED sequencer; a zero length ends the phase on the next tick
  function void advance_leds(logic ok, output logic attempt, output logic done);
    attempt = 1'b0;
    done    = 1'b0;
    if (led_phase == PH_IDLE) return;
    if (phase_elapsed < PHASE_MAX) phase_elapsed++;
    if (phase_elapsed < phase_length) return;
    case (led_phase)
      PH_PRE_ON1:   begin led_level = 1'b0; arm_phase(PH_PRE_OFF1, BLINK_MS); end
      PH_PRE_OFF1:  begin led_level = 1'b1; arm_phase(PH_PRE_ON2, BLINK_MS); end
      PH_PRE_ON2:   begin led_level = 1'b0; arm_phase(PH_PRE_OFF2, BLINK_MS); end
      PH_PRE_OFF2:  begin fail_count = '0; arm_phase(PH_TRY, '0); end
      PH_TRY: begin
        attempt = 1'b1;
        if (ok) begin
          arm_phase(PH_POST_WAIT, live_cfg.post_wait_ms);
        end else begin
          if (fail_count < FAIL_MAX) fail_count++;
          if (fail_count >= live_cfg.max_attempts) begin
            led_level = 1'b1;
            arm_phase(PH_FAIL_ON1, live_cfg.fail_flash_ms);
          end else begin
            arm_phase(PH_RETRY, live_cfg.retry_delay_ms);
          end
        end
      end
      PH_RETRY:     arm_phase(PH_TRY, '0);
      PH_POST_WAIT: begin led_level = 1'b1; arm_phase(PH_POST_ON1, BLINK_MS); end
      PH_POST_ON1:  begin led_level = 1'b0; arm_phase(PH_POST_OFF1, BLINK_MS); end
      PH_POST_OFF1: begin led_level = 1'b1; arm_phase(PH_POST_ON2, BLINK_MS); end
      PH_POST_ON2:  begin led_level = 1'b0; arm_phase(PH_POST_OFF2, BLINK_MS); end
      PH_FAIL_ON1:  begin led_level = 1'b0; arm_phase(PH_FAIL_OFF1, live_cfg.fail_flash_ms); end
      PH_FAIL_OFF1: begin led_level = 1'b1; arm_phase(PH_FAIL_ON2, live_cfg.fail_flash_ms); end
      PH_FAIL_ON2:  begin led_level = 1'b0; arm_phase(PH_FAIL_OFF2, live_cfg.fail_flash_ms); end
      PH_FAIL_OFF2: begin led_level = 1'b1; arm_phase(PH_FAIL_ON3, live_cfg.fail_flash_ms); end
      PH_FAIL_ON3:  begin led_level = 1'b0; arm_phase(PH_FAIL_OFF3, live_cfg.fail_flash_ms); end
      PH_POST_OFF2, PH_FAIL_OFF3: begin
        arm_phase(PH_IDLE, '0);
        done = 1'b1;
      end
      default:      arm_phase(PH_IDLE, '0);
    endcase
  endfunction

  // debounce, then press timing, then the sequencer
  function out_item_t run_tick(in_item_t t);
    out_item_t r;
    logic started, attempt, done, portal, factory;
    started = 1'b0;
    portal  = 1'b0;
    factory = 1'b0;
    if (t.button_raw != last_raw) begin
      last_raw     = t.button_raw;
      stable_ticks = '0;
    end else if (stable_ticks < STABLE_MAX) begin
      stable_ticks++;
    end
    if (stable_ticks >= live_cfg.debounce_ms) debounced = last_raw;

    if (held_down && hold_ticks < HOLD_MAX) hold_ticks++;
    if (debounced) begin
      if (!held_down) begin
        held_down   = 1'b1;
        hold_ticks  = '0;
        reset_fired = 1'b0;
      end else if (!reset_fired && hold_ticks >= live_cfg.factory_hold_ms) begin
        reset_fired = 1'b1;
        factory     = 1'b1;
      end
    end else if (held_down) begin
      // windows tested in order; crossed bounds leave a window empty
      if (!reset_fired && hold_ticks >= live_cfg.short_min_ms &&
          hold_ticks < live_cfg.portal_min_ms) begin
        if (led_phase == PH_IDLE) begin
          led_level = 1'b1;
          arm_phase(PH_PRE_ON1, BLINK_MS);
          started = 1'b1;
        end
      end else if (!reset_fired && hold_ticks >= live_cfg.portal_min_ms &&
                   hold_ticks < live_cfg.factory_hold_ms) begin
        portal = 1'b1;
      end
      held_down   = 1'b0;
      reset_fired = 1'b0;
    end

    attempt = 1'b0;
    done    = 1'b0;
    if (!started) advance_leds(t.publish_ok, attempt, done);

    r.led_on          = led_level;
    r.led_hold        = done;
    r.publish_attempt = attempt;
    r.portal_request  = portal;
    r.factory_reset   = factory;
    r.sequence_active = (led_phase != PH_IDLE);
    r.button_level    = debounced;
    return r;
  endfunction

  function string fmt(out_item_t o);
    return $sformatf("led=%b hold=%b try=%b portal=%b factory=%b active=%b level=%b",
                     o.led_on, o.led_hold, o.publish_attempt, o.portal_request,
                     o.factory_reset, o.sequence_active, o.button_level);
  endfunction

  function void flag(string msg);
    if (mismatches < 10) $display("%s", msg);
    mismatches++;
  endfunction

  // driver: predict on each input transfer, then present the next tick
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) tick_results.push_back(run_tick(in_data));
      if (!(push && full)) begin
        if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data <= pending_ticks.pop_front();
          ticks_issued++;
          push <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // monitor: check each result transfer against the oldest prediction
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (tick_results.size() == 0) begin
          flag($sformatf("%0t: result with no tick pending: %s", $time, fmt(out_data)));
        end else begin
          want = tick_results.pop_front();
          ticks_checked++;
          if (out_data !== want)
            flag($sformatf("%0t: tick %0d expected %s got %s", $time, ticks_checked,
                           fmt(want), fmt(out_data)));
        end
      end
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("button_gesture_led_sequencer_unit verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic cfg_write(reg_idx_t idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_DEBOUNCE:     live_cfg.debounce_ms     = val[7:0];
      REG_SHORT_MIN:    live_cfg.short_min_ms    = val;
      REG_PORTAL_MIN:   live_cfg.portal_min_ms   = val;
      REG_FACTORY_HOLD: live_cfg.factory_hold_ms = val;
      REG_MAX_ATTEMPTS: live_cfg.max_attempts    = val[2:0];
      REG_RETRY_DELAY:  live_cfg.retry_delay_ms  = val[9:0];
      REG_FAIL_FLASH:   live_cfg.fail_flash_ms   = val[9:0];
      REG_POST_WAIT:    live_cfg.post_wait_ms    = val[9:0];
      default: ;
    endcase
  endtask

  // full register set; unused upper data bits carry junk
  task automatic load_cfg(cfg_t c);
    cfg_write(REG_DEBOUNCE,     {8'($urandom), c.debounce_ms});
    cfg_write(REG_SHORT_MIN,    c.short_min_ms);
    cfg_write(REG_PORTAL_MIN,   c.portal_min_ms);
    cfg_write(REG_FACTORY_HOLD, c.factory_hold_ms);
    cfg_write(REG_MAX_ATTEMPTS, {13'($urandom), c.max_attempts});
    cfg_write(REG_RETRY_DELAY,  {6'($urandom), c.retry_delay_ms});
    cfg_write(REG_FAIL_FLASH,   {6'($urandom), c.fail_flash_ms});
    cfg_write(REG_POST_WAIT,    {6'($urandom), c.post_wait_ms});
    cfg_valid <= 1'b0;
  endtask

  // sender holds off until every pushed tick has its result back
  task automatic settle();
    while (pending_ticks.size() != 0 || ticks_issued != ticks_checked) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic add_tick(logic raw, logic ok);
    in_item_t t;
    t.button_raw = raw;
    t.publish_ok = ok;
    pending_ticks.push_back(t);
    queued++;
  endtask

  task automatic add_ticks(logic raw, int n, int ok_pct);
    repeat (n) add_tick(raw, 1'($urandom_range(99) < ok_pct));
  endtask

  // one press aimed at a window, or plain chatter
  task automatic add_gesture(cfg_t c, int ok_pct);
    int kind;
    int len;
    kind = $urandom_range(99);
    if (kind < 12) begin
      repeat ($urandom_range(6, 1)) add_ticks(1'($urandom_range(1)), 1, ok_pct);
    end else begin
      if (kind < 62)      len = c.short_min_ms + $urandom_range(2);
      else if (kind < 82) len = c.portal_min_ms + $urandom_range(2);
      else                len = c.factory_hold_ms + $urandom_range(3);
      if (len < c.debounce_ms + 1) len = c.debounce_ms + 1 + $urandom_range(2);
      // bounce on the press edge now and then
      if ($urandom_range(3) == 0) begin
        add_ticks(1'b1, 1, ok_pct);
        add_ticks(1'b0, 1, ok_pct);
      end
      add_ticks(1'b1, len, ok_pct);
      add_ticks(1'b0, c.debounce_ms + 1 + $urandom_range(10), ok_pct);
    end
  endtask

  // small timings so sequences finish within a few hundred ticks
  function automatic cfg_t rand_cfg();
    cfg_t c;
    c.debounce_ms     = 8'($urandom_range(4));
    c.short_min_ms    = 16'($urandom_range(8, 1));
    c.portal_min_ms   = c.short_min_ms + 16'($urandom_range(12, 1));
    c.factory_hold_ms = c.portal_min_ms + 16'($urandom_range(12, 1));
    // now and then cross the thresholds so a window is empty
    if ($urandom_range(3) == 0) c.portal_min_ms = 16'($urandom_range(c.short_min_ms, 1));
    if ($urandom_range(3) == 0) c.factory_hold_ms = 16'($urandom_range(c.portal_min_ms, 1));
    c.max_attempts    = 3'($urandom_range(7));
    c.retry_delay_ms  = 10'($urandom_range(6));
    c.fail_flash_ms   = 10'($urandom_range(6, 1));
    c.post_wait_ms    = 10'($urandom_range(10));
    return c;
  endfunction

  initial begin
    cfg_t c;
    int   ok_pct;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: zero debounce, zero attempts, tiny windows
    send_idle_pct = 15;
    recv_idle_pct = 77;
    c = '{debounce_ms: 8'd0, short_min_ms: 16'd1, portal_min_ms: 16'd3,
          factory_hold_ms: 16'd6, max_attempts: 3'd0, retry_delay_ms: 10'd0,
          fail_flash_ms: 10'd1, post_wait_ms: 10'd0};
    load_cfg(c);
    add_tick(1'b0, 1'b0);
    // short press starts the sequence on release
    add_tick(1'b1, 1'b1);
    add_tick(1'b1, 1'b0);
    add_tick(1'b0, 1'b1);
    // portal-length press
    repeat (2) begin
      add_tick(1'b1, 1'b0);
      add_tick(1'b1, 1'b1);
    end
    add_tick(1'b0, 1'b0);
    // factory hold, pulse once, then a silent release
    repeat (7) add_tick(1'b1, 1'b1);
    add_tick(1'b1, 1'b0);
    add_tick(1'b0, 1'b1);
    // short press while the sequence is busy
    add_tick(1'b1, 1'b0);
    add_tick(1'b0, 1'b1);
    add_tick(1'b1, 1'b1);
    add_tick(1'b0, 1'b0);
    settle();

    // random phases under changing register sets and idling
    for (int p = 1; p <= 9; p++) begin
      if (p == 4) begin
        send_idle_pct = 77;
        recv_idle_pct = 15;
      end
      if (p == 7) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      c = rand_cfg();
      if (p == 1) c.max_attempts = 3'd0;
      load_cfg(c);
      case ($urandom_range(2))
        0:       ok_pct = 20;
        1:       ok_pct = 50;
        default: ok_pct = 85;
      endcase
      queued = 0;
      while (queued < 40) add_gesture(c, ok_pct);
      settle();
    end

    // register extremes: long debounce saturates the stable count, slow sequence
    c = '{debounce_ms: 8'd255, short_min_ms: 16'd1, portal_min_ms: 16'hFFFF,
          factory_hold_ms: 16'hFFFF, max_attempts: 3'd7, retry_delay_ms: 10'd1023,
          fail_flash_ms: 10'd1023, post_wait_ms: 10'd1023};
    load_cfg(c);
    add_ticks(1'b1, 280, 30);
    add_ticks(1'b0, 280, 30);
    settle();

    if (mismatches == 0) begin
      $display("button_gesture_led_sequencer_unit verification clean");
    end else begin
      $display("button_gesture_led_sequencer_unit verification failed");
    end
    $finish;
  end

endmodule
